>>> rtl/cp1251_pkg.sv
// ----------------------------------------------------------------------------
// cp1251_pkg
// Shared types, constants and code mapping for the case-insensitive
// cp1251 string compare.
// ----------------------------------------------------------------------------
package cp1251_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_END   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  localparam int unsigned CharW  = 16;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned CountW = 17;

  localparam logic [CountW-1:0] CountMax = '1;

  // codes at or above this bypass mapping and folding
  localparam logic [CharW-1:0] MapLimit   = 16'h1000;
  localparam logic [CodeW-1:0] CyrBase    = 12'h400;
  localparam logic [CodeW-1:0] CyrLow     = 12'd16;
  localparam logic [CodeW-1:0] CyrHigh    = 12'd79;
  localparam logic [CodeW-1:0] CyrShift   = 12'd176;
  localparam logic [7:0]       FoldMask   = 8'hDF;

  // offsets from the cyrillic base with dedicated codes
  localparam logic [CodeW-1:0] OfsIo      = 12'h001;
  localparam logic [CodeW-1:0] OfsUkrYe   = 12'h004;
  localparam logic [CodeW-1:0] OfsUkrI    = 12'h006;
  localparam logic [CodeW-1:0] OfsIoLow   = 12'h051;
  localparam logic [CodeW-1:0] OfsYeLow   = 12'h054;
  localparam logic [CodeW-1:0] OfsILow    = 12'h056;
  localparam logic [CodeW-1:0] OfsYiLow   = 12'h057;

  localparam logic [CodeW-1:0] CodeIo     = 12'd168;
  localparam logic [CodeW-1:0] CodeUkrYe  = 12'd170;
  localparam logic [CodeW-1:0] CodeUkrI   = 12'd178;
  localparam logic [CodeW-1:0] CodeIoLow  = 12'd184;
  localparam logic [CodeW-1:0] CodeYeLow  = 12'd186;
  localparam logic [CodeW-1:0] CodeILow   = 12'd179;
  localparam logic [CodeW-1:0] CodeYiLow  = 12'd191;

  // unicode cyrillic to single-byte code, unmapped codes give the raw offset
  function automatic logic [CodeW-1:0] map_code(input logic [CodeW-1:0] c);
    logic [CodeW-1:0] d;
    logic [CodeW-1:0] r;
    d = c - CyrBase;
    if (c < CyrBase) begin
      r = c;
    end else if (d < CyrLow) begin
      if (d == OfsIo) r = CodeIo;
      else if (d == OfsUkrYe) r = CodeUkrYe;
      else if (d == OfsUkrI) r = CodeUkrI;
      else r = d;
    end else if (d > CyrHigh) begin
      if (d == OfsIoLow) r = CodeIoLow;
      else if (d == OfsYeLow) r = CodeYeLow;
      else if (d == OfsILow) r = CodeILow;
      else if (d == OfsYiLow) r = CodeYiLow;
      else r = d;
    end else begin
      r = d + CyrShift;
    end
    return r;
  endfunction

  // fold case: with bit 6 set, keep the low byte and clear bit 5
  function automatic logic [CodeW-1:0] fold_code(input logic [CodeW-1:0] c);
    logic [CodeW-1:0] r;
    if (c[6]) r = {{(CodeW-8){1'b0}}, c[7:0] & FoldMask};
    else r = c;
    return r;
  endfunction

endpackage

>>> rtl/cp1251_nocase_string_compare.sv
// ----------------------------------------------------------------------------
// cp1251_nocase_string_compare
// Case-insensitive compare of two 16-bit character streams after mapping
// cyrillic codes to cp1251, reporting the first signed difference.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid_i/in_ready_o | kind, char_a/b, limited,
//          |           |                       | limit_n, len_a/b
//  out     | output    | out_valid_o/out_ready_i | difference (17-bit signed)
//
//  one beat per cycle unless an end beat stalls; a beat is registered, then
//  processed against the compare state; an end beat's result is registered
//  in turn, so it passes the input register and then the result register.
//  only an end beat can stall, while a previous result waits to be taken.
//  rst_ni clears the compare state to unlimited mode with no difference.
// ----------------------------------------------------------------------------
module cp1251_nocase_string_compare (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             kind_i,
  input  logic [cp1251_pkg::CharW-1:0]           char_a_i,
  input  logic [cp1251_pkg::CharW-1:0]           char_b_i,
  input  logic                                   limited_i,
  input  logic [cp1251_pkg::CharW-1:0]           limit_n_i,
  input  logic [cp1251_pkg::CharW-1:0]           len_a_i,
  input  logic [cp1251_pkg::CharW-1:0]           len_b_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cp1251_pkg::DiffW-1:0]    difference_o
);

  localparam int unsigned CharW  = cp1251_pkg::CharW;
  localparam int unsigned CodeW  = cp1251_pkg::CodeW;
  localparam int unsigned DiffW  = cp1251_pkg::DiffW;
  localparam int unsigned CountW = cp1251_pkg::CountW;

  // input register
  logic             s1_valid_q;
  logic [1:0]       s1_kind_q;
  logic [CharW-1:0] s1_a_q, s1_b_q, s1_limit_n_q, s1_len_a_q, s1_len_b_q;
  logic             s1_limited_q;

  // compare state
  logic              decided_q, decided_d;
  logic              limit_mode_q, limit_mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] limit_q, limit_d;
  logic [DiffW-1:0]  latched_q, latched_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [DiffW-1:0] diff_q, diff_d;

  logic             out_free;
  logic             s1_fire;
  cp1251_pkg::kind_e kind;
  logic [CodeW-1:0] code_a, code_b;
  logic [DiffW-1:0] pair_diff;
  logic             pair_take;

  assign kind     = cp1251_pkg::kind_e'(s1_kind_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_fire  = s1_valid_q && ((kind != cp1251_pkg::KIND_END) || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // map and fold both characters when both are in the mapped range
  always_comb begin
    code_a = cp1251_pkg::fold_code(cp1251_pkg::map_code(s1_a_q[CodeW-1:0]));
    code_b = cp1251_pkg::fold_code(cp1251_pkg::map_code(s1_b_q[CodeW-1:0]));
    if (s1_a_q < cp1251_pkg::MapLimit && s1_b_q < cp1251_pkg::MapLimit) begin
      pair_diff = {{(DiffW-CodeW){1'b0}}, code_a} - {{(DiffW-CodeW){1'b0}}, code_b};
    end else begin
      pair_diff = {1'b0, s1_a_q} - {1'b0, s1_b_q};
    end
    pair_take = !decided_q && !(limit_mode_q && (count_q >= limit_q));
  end

  // state update and result
  always_comb begin
    decided_d    = decided_q;
    limit_mode_d = limit_mode_q;
    count_d      = count_q;
    limit_d      = limit_q;
    latched_d    = latched_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    diff_d       = diff_q;
    if (s1_fire) begin
      case (kind)
        cp1251_pkg::KIND_START: begin
          decided_d    = 1'b0;
          count_d      = '0;
          latched_d    = '0;
          limit_mode_d = s1_limited_q;
          limit_d      = {1'b0, s1_limit_n_q} + CountW'(1);
        end
        cp1251_pkg::KIND_PAIR: begin
          if (pair_take) begin
            if (count_q != cp1251_pkg::CountMax) count_d = count_q + CountW'(1);
            if (pair_diff != '0) begin
              decided_d = 1'b1;
              latched_d = pair_diff;
            end
          end
        end
        cp1251_pkg::KIND_END: begin
          out_valid_d = 1'b1;
          if (decided_q) diff_d = latched_q;
          else if (limit_mode_q) diff_d = '0;
          else diff_d = {1'b0, s1_len_a_q} - {1'b0, s1_len_b_q};
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      decided_q    <= 1'b0;
      limit_mode_q <= 1'b0;
      count_q      <= '0;
      limit_q      <= '0;
      latched_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      decided_q    <= decided_d;
      limit_mode_q <= limit_mode_d;
      count_q      <= count_d;
      limit_q      <= limit_d;
      latched_q    <= latched_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q    <= kind_i;
      s1_a_q       <= char_a_i;
      s1_b_q       <= char_b_i;
      s1_limited_q <= limited_i;
      s1_limit_n_q <= limit_n_i;
      s1_len_a_q   <= len_a_i;
      s1_len_b_q   <= len_b_i;
    end
    diff_q <= diff_d;
  end

  assign out_valid_o  = out_valid_q;
  assign difference_o = signed'(diff_q);

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the case-insensitive cp1251 string compare. A queue
// of beats feeds a clocked driver, a clocked monitor predicts each accepted
// beat and checks every returned difference, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    cp1251_pkg::kind_e kind;
    logic [15:0]       ch_a;
    logic [15:0]       ch_b;
    logic              lim;
    logic [15:0]       lim_n;
    logic [15:0]       len_a;
    logic [15:0]       len_b;
  } cmp_beat_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // dut side signals
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] difference;
  cmp_beat_t          cur_beat = '{cp1251_pkg::KIND_NONE, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0,
                                   16'h0};

  cp1251_nocase_string_compare dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (cur_beat.kind),
    .char_a_i    (cur_beat.ch_a),
    .char_b_i    (cur_beat.ch_b),
    .limited_i   (cur_beat.lim),
    .limit_n_i   (cur_beat.lim_n),
    .len_a_i     (cur_beat.len_a),
    .len_b_i     (cur_beat.len_b),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .difference_o(difference)
  );

  // shared bench state
  cmp_beat_t          beats_to_send[$];
  logic signed [16:0] diff_expected_q[$];
  logic               in_beat_taken = 1'b0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 stall_req = 0;
  int                 stall_ack = 0;
  int                 hold_left = 0;
  int                 err_cnt = 0;

  // predictor state
  logic [16:0]        pos_cnt = '0;
  logic               diff_locked = 1'b0;
  logic signed [16:0] first_diff = '0;
  logic               lim_mode = 1'b0;
  logic [16:0]        pos_limit = '0;

  // unicode cyrillic to single-byte code, then case fold
  function automatic logic [15:0] cp1251_fold(input logic [15:0] c);
    logic [15:0] ofs;
    logic [15:0] m;
    if (c < 16'h0400) begin
      m = c;
    end else begin
      ofs = c - 16'h0400;
      if (ofs >= 16'd16 && ofs <= 16'd79) begin
        m = ofs + 16'd176;
      end else begin
        case (ofs)
          16'h001: m = 16'd168;
          16'h004: m = 16'd170;
          16'h006: m = 16'd178;
          16'h051: m = 16'd184;
          16'h054: m = 16'd186;
          16'h056: m = 16'd179;
          16'h057: m = 16'd191;
          default: m = ofs;
        endcase
      end
    end
    // letters carry bit 6, lower case adds bit 5
    if (m[6]) m = m & 16'h00DF;
    return m;
  endfunction

  // advance the compare state on one accepted beat
  task automatic track_compare(input cmp_beat_t b);
    logic [15:0] ca;
    logic [15:0] cb;
    int          d;
    case (b.kind)
      cp1251_pkg::KIND_START: begin
        pos_cnt     = '0;
        diff_locked = 1'b0;
        first_diff  = '0;
        lim_mode    = b.lim;
        pos_limit   = {1'b0, b.lim_n} + 17'd1;
      end
      cp1251_pkg::KIND_PAIR: begin
        if (!diff_locked && !(lim_mode && pos_cnt >= pos_limit)) begin
          if (pos_cnt != '1) pos_cnt = pos_cnt + 17'd1;
          ca = b.ch_a;
          cb = b.ch_b;
          if (ca < 16'h1000 && cb < 16'h1000) begin
            ca = cp1251_fold(ca);
            cb = cp1251_fold(cb);
          end
          d = int'(ca) - int'(cb);
          if (d != 0) begin
            diff_locked = 1'b1;
            first_diff  = d[16:0];
          end
        end
      end
      cp1251_pkg::KIND_END: begin
        if (diff_locked) d = first_diff;
        else if (lim_mode) d = 0;
        else d = int'(b.len_a) - int'(b.len_b);
        diff_expected_q.push_back(d[16:0]);
      end
      default: ;
    endcase
  endtask

  // driver: a new beat only once the current one is gone
  always @(negedge clk_i) begin
    if (rst_n && (!in_valid || in_beat_taken)) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_beat <= beats_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold on request, random stalls otherwise
  always @(negedge clk_i) begin
    if (stall_ack != stall_req) begin
      stall_ack <= stall_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    logic signed [16:0] want;
    if (rst_n) begin
      in_beat_taken <= in_valid && in_ready;
      if (in_valid && in_ready) track_compare(cur_beat);
      if (out_valid && out_ready) begin
        if (diff_expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: difference %0d returned, expected none", $time, difference);
        end else begin
          want = diff_expected_q.pop_front();
          if (difference !== want) begin
            err_cnt++;
            $display("%0t: difference expected %0d, got %0d", $time, want, difference);
          end
        end
      end
    end
  end

  // beat builders, unused fields random
  function automatic cmp_beat_t mk_any(input cp1251_pkg::kind_e k);
    cmp_beat_t b;
    b.kind  = k;
    b.ch_a  = 16'($urandom);
    b.ch_b  = 16'($urandom);
    b.lim   = 1'($urandom);
    b.lim_n = 16'($urandom);
    b.len_a = 16'($urandom);
    b.len_b = 16'($urandom);
    return b;
  endfunction

  function automatic cmp_beat_t mk_start(input logic lim, input logic [15:0] n);
    cmp_beat_t b;
    b       = mk_any(cp1251_pkg::KIND_START);
    b.lim   = lim;
    b.lim_n = n;
    return b;
  endfunction

  function automatic cmp_beat_t mk_pair(input logic [15:0] a, input logic [15:0] c);
    cmp_beat_t b;
    b      = mk_any(cp1251_pkg::KIND_PAIR);
    b.ch_a = a;
    b.ch_b = c;
    return b;
  endfunction

  function automatic cmp_beat_t mk_end(input logic [15:0] la, input logic [15:0] lb);
    cmp_beat_t b;
    b       = mk_any(cp1251_pkg::KIND_END);
    b.len_a = la;
    b.len_b = lb;
    return b;
  endfunction

  // character mix weighted toward cyrillic and latin letters
  function automatic logic [15:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2: return 16'h0410 + 16'($urandom_range(63));
      3:       return 16'h0400 + 16'($urandom_range(95));
      4: begin
        case ($urandom_range(6))
          0: return 16'h0401;
          1: return 16'h0404;
          2: return 16'h0406;
          3: return 16'h0451;
          4: return 16'h0454;
          5: return 16'h0456;
          default: return 16'h0457;
        endcase
      end
      5, 6:    return 16'h0041 + 16'($urandom_range(25)) + ($urandom_range(1) ? 16'h20 : 16'h0);
      7:       return 16'($urandom_range(16'h0fff));
      8:       return 16'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return 16'h0fff;
          1: return 16'h1000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  // other case of a letter where one exists
  function automatic logic [15:0] flip_case(input logic [15:0] a);
    if (a >= 16'h0410 && a < 16'h0430) return a + 16'h20;
    if (a >= 16'h0430 && a < 16'h0450) return a - 16'h20;
    if (a >= 16'h0400 && a < 16'h0410) return a + 16'h50;
    if (a >= 16'h0450 && a < 16'h0460) return a - 16'h50;
    if ((a >= 16'h0041 && a <= 16'h005a) || (a >= 16'h0061 && a <= 16'h007a))
      return a ^ 16'h20;
    return a;
  endfunction

  task automatic send_beat(input cmp_beat_t b);
    while (beats_to_send.size() >= 16) @(posedge clk_i);
    beats_to_send.push_back(b);
  endtask

  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_valid || diff_expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  // start, character pairs, end; returns beats sent
  task automatic send_string_pair(output int n);
    int          pairs;
    int          extra;
    logic [15:0] a;
    logic [15:0] c;
    if ($urandom_range(7) == 0) send_beat(mk_start(1'($urandom), 16'($urandom)));
    else send_beat(mk_start(1'($urandom), 16'($urandom_range(12))));
    pairs = $urandom_range(12);
    repeat (pairs) begin
      a = pick_char();
      case ($urandom_range(5))
        0, 1, 2: c = a;
        3, 4:    c = flip_case(a);
        default: c = pick_char();
      endcase
      send_beat(mk_pair(a, c));
    end
    extra = $urandom_range(5);
    if ($urandom_range(9) == 0) send_beat(mk_end(16'($urandom), 16'($urandom)));
    else if ($urandom_range(1)) send_beat(mk_end(16'(pairs), 16'(pairs + extra)));
    else send_beat(mk_end(16'(pairs + extra), 16'(pairs)));
    n = pairs + 2;
  endtask

  int send_pcts[4] = '{0, 84, 0, 11};
  int recv_pcts[4] = '{0, 0, 84, 11};

  // stimulus
  initial begin
    int          sent;
    int          n;
    int          i;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // directed: reset state, repeats, extremes, special codes, limits
    send_beat(mk_pair(16'h0041, 16'h0061));
    send_beat(mk_end(16'd3, 16'd5));
    send_beat(mk_any(cp1251_pkg::KIND_NONE));
    send_beat(mk_end(16'd9, 16'd1));
    send_beat(mk_start(1'b0, 16'h0000));
    send_beat(mk_pair(16'h0410, 16'h0430));
    send_beat(mk_pair(16'h0404, 16'h0454));
    send_beat(mk_pair(16'h0401, 16'h0451));
    send_beat(mk_pair(16'hffff, 16'h0000));
    send_beat(mk_end(16'd3, 16'd3));
    send_beat(mk_start(1'b1, 16'h0000));
    send_beat(mk_pair(16'h0406, 16'h0456));
    send_beat(mk_pair(16'h0407, 16'h0457));
    send_beat(mk_end(16'hffff, 16'h0000));
    send_beat(mk_start(1'b0, 16'hffff));
    send_beat(mk_pair(16'hffff, 16'h0000));
    send_beat(mk_end(16'd0, 16'd0));
    send_beat(mk_start(1'b0, 16'h0000));
    send_beat(mk_pair(16'h0000, 16'hffff));
    send_beat(mk_end(16'd0, 16'd0));
    send_beat(mk_start(1'b0, 16'h0000));
    send_beat(mk_pair(16'h0fff, 16'h1000));
    send_beat(mk_end(16'd1, 16'd1));
    send_beat(mk_start(1'b0, 16'h0000));
    send_beat(mk_end(16'hffff, 16'h0000));
    send_beat(mk_end(16'h0000, 16'hffff));
    wait_drained();

    // long receiver hold while the sender keeps offering end beats
    stall_req = stall_req + 1;
    send_beat(mk_start(1'b0, 16'd0));
    send_beat(mk_pair(16'h0042, 16'h0062));
    repeat (8) send_beat(mk_end(16'($urandom_range(20)), 16'($urandom_range(20))));
    send_beat(mk_start(1'b0, 16'd0));
    send_beat(mk_pair(16'h0431, 16'h0432));
    repeat (6) send_beat(mk_end(16'($urandom), 16'($urandom)));
    wait_drained();
    repeat (4) @(posedge clk_i);

    // random sequences across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      sent = 0;
      while (sent < 210) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 3))
            send_beat(mk_any(cp1251_pkg::kind_e'($urandom_range(3))));
        end else begin
          send_string_pair(n);
          sent += n;
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // drain with a bounded wait
    i = 0;
    while ((beats_to_send.size() != 0 || in_valid || diff_expected_q.size() != 0)
           && i < 5000) begin
      @(posedge clk_i);
      i++;
    end
    repeat (10) @(posedge clk_i);
    if (diff_expected_q.size() != 0 || beats_to_send.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected differences never returned", $time,
               diff_expected_q.size());
    end
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
